// ===== rtl/qau_pkg.sv =====
// Shared types and constants of the quaternion arithmetic unit.
// No dependencies; used by the interfaces, the top level and the clamp stage.
package qau_pkg;

   localparam int DW = 32;   // component width, fixed by the transaction format
   localparam int CW = 3;    // operation code width

   localparam logic signed [DW-1:0] COMP_MAX = 32'sh7fff_ffff;
   localparam logic signed [DW-1:0] COMP_MIN = 32'sh8000_0000;

   typedef enum logic [CW-1:0] {
      CMD_MULT   = 3'd0,
      CMD_SUM    = 3'd1,
      CMD_SUB    = 3'd2,
      CMD_CONJ   = 3'd3,
      CMD_SCALE  = 3'd4,
      CMD_DOT    = 3'd5,
      CMD_ROTATE = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [CW-1:0]        cmd;
      logic signed [DW-1:0] a_w;
      logic signed [DW-1:0] a_x;
      logic signed [DW-1:0] a_y;
      logic signed [DW-1:0] a_z;
      logic signed [DW-1:0] b_w;
      logic signed [DW-1:0] b_x;
      logic signed [DW-1:0] b_y;
      logic signed [DW-1:0] b_z;
      logic signed [DW-1:0] factor;
   } req_payload_type;

   typedef struct packed {
      logic signed [DW-1:0] r_w;
      logic signed [DW-1:0] r_x;
      logic signed [DW-1:0] r_y;
      logic signed [DW-1:0] r_z;
      logic                 saturated;
   } rsp_payload_type;

endpackage

// ===== rtl/qau_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on qau_pkg for the payload types.
interface qau_req_if;
   logic                     valid;
   logic                     ready;
   qau_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface qau_rsp_if;
   logic                     valid;
   logic                     ready;
   qau_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit top level: seven-stage pipeline.
// Depends on qau_pkg, qau_if, qau_mul_bank and qau_clamp_stage.
//
// Usage: a request transaction on req_chan carries cmd, quaternions a and b
// and a scale factor, all signed fixed point with FRAC_BITS fraction bits.
// Each request gives exactly one response transaction on rsp_chan, in order,
// with the four result components and a saturation flag.
// Throughput is one transaction per cycle, sustained while rsp_chan.ready stays
// high. The result is shown on rsp_chan after the seven register stages:
// input, first product bank, sums, clamp, second product bank (for
// rotation by conj(a)), sums, output clamp register.
// Every stage holds a valid bit; a stage loads when it is empty or when the
// stage after it moves on, so bubbles close up and req_chan.ready stays high
// while any stage of the pipe is free, even with a result waiting on rsp.
// When the receiver stalls, the pipe fills and then holds; nothing is lost
// or repeated. Synchronous reset clears the valid bits only; the data
// registers are not reset.
module quaternion_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   qau_req_if.sink    req_chan,
   qau_rsp_if.source  rsp_chan
);

   localparam int DW  = qau_pkg::DW;
   localparam int SW  = 66 - FRAC_BITS;   // exact width of a four-term sum
   localparam int LW  = DW + 1;           // linear op and conjugate width
   localparam int P1W = DW + DW;
   localparam int P2W = DW + LW;

   // ---- stage enables and valids ----
   logic va_ff, vm1_ff, vs1_ff, vc1_ff, vm2_ff, vs2_ff, vo_ff;
   logic en_a, en_m1, en_s1, en_c1, en_m2, en_s2, en_o;

   assign en_o  = !vo_ff  || rsp_chan.ready;
   assign en_s2 = !vs2_ff || en_o;
   assign en_m2 = !vm2_ff || en_s2;
   assign en_c1 = !vc1_ff || en_m2;
   assign en_s1 = !vs1_ff || en_c1;
   assign en_m1 = !vm1_ff || en_s1;
   assign en_a  = !va_ff  || en_m1;

   assign req_chan.ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vm1_ff <= 1'b0;
         vs1_ff <= 1'b0;
         vc1_ff <= 1'b0;
         vm2_ff <= 1'b0;
         vs2_ff <= 1'b0;
         vo_ff  <= 1'b0;
      end else begin
         if (en_a)  va_ff  <= req_chan.valid;
         if (en_m1) vm1_ff <= va_ff;
         if (en_s1) vs1_ff <= vm1_ff;
         if (en_c1) vc1_ff <= vs1_ff;
         if (en_m2) vm2_ff <= vc1_ff;
         if (en_s2) vs2_ff <= vm2_ff;
         if (en_o)  vo_ff  <= vs2_ff;
      end
   end

   // ---- input register ----
   qau_pkg::req_payload_type pa_ff;

   always_ff @(posedge clock) begin
      if (en_a) pa_ff <= req_chan.payload;
   end

   // operands of the first bank; b_w slot carries factor for scale, zero for rotate
   logic signed [DW-1:0] opa [4];
   logic signed [DW-1:0] opb [4];
   logic signed [LW-1:0] lin_in [4];

   always_comb begin
      opa[0] = pa_ff.a_w;
      opa[1] = pa_ff.a_x;
      opa[2] = pa_ff.a_y;
      opa[3] = pa_ff.a_z;
      opb[1] = pa_ff.b_x;
      opb[2] = pa_ff.b_y;
      opb[3] = pa_ff.b_z;
      if (pa_ff.cmd == qau_pkg::CMD_SCALE) begin
         opb[0] = pa_ff.factor;
      end else if (pa_ff.cmd == qau_pkg::CMD_ROTATE) begin
         opb[0] = '0;
      end else begin
         opb[0] = pa_ff.b_w;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) lin_in[k] = '0;
      case (pa_ff.cmd)
         qau_pkg::CMD_SUM: begin
            for (int k = 0; k < 4; k++) lin_in[k] = LW'(opa[k]) + LW'(opb[k]);
            lin_in[0] = LW'(pa_ff.a_w) + LW'(pa_ff.b_w);
         end
         qau_pkg::CMD_SUB: begin
            for (int k = 0; k < 4; k++) lin_in[k] = LW'(opa[k]) - LW'(opb[k]);
            lin_in[0] = LW'(pa_ff.a_w) - LW'(pa_ff.b_w);
         end
         qau_pkg::CMD_CONJ: begin
            for (int k = 1; k < 4; k++) lin_in[k] = -LW'(opa[k]);
            lin_in[0] = LW'(pa_ff.a_w);
         end
         default: begin
            for (int k = 0; k < 4; k++) lin_in[k] = '0;
         end
      endcase
   end

   // ---- stage M1: first product bank ----
   logic signed [P1W-1:0] p1 [4][4];
   logic [qau_pkg::CW-1:0] cm1_ff;
   logic signed [DW-1:0]   am1_ff [4];
   logic signed [LW-1:0]   lin_ff [4];

   qau_mul_bank #(.AW(DW), .BW(DW)) u_bank1 (
      .clock (clock),
      .load  (en_m1),
      .a_i   (opa),
      .b_i   (opb),
      .p_o   (p1)
   );

   always_ff @(posedge clock) begin
      if (en_m1) begin
         cm1_ff <= pa_ff.cmd;
         am1_ff <= opa;
         lin_ff <= lin_in;
      end
   end

   // ---- stage S1: Hamilton sums, dot, scale, op selection ----
   logic signed [P1W-1:0] sh1;
   logic signed [SW-1:0]  q1 [4][4];
   logic signed [SW-1:0]  s1_in [4];
   logic signed [SW-1:0]  s1_ff [4];
   logic [qau_pkg::CW-1:0] cs1_ff;
   logic signed [DW-1:0]   as1_ff [4];

   always_comb begin
      sh1 = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            sh1      = p1[i][j] >>> FRAC_BITS;
            q1[i][j] = sh1[SW-1:0];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) s1_in[k] = '0;
      case (cm1_ff)
         qau_pkg::CMD_MULT, qau_pkg::CMD_ROTATE: begin
            s1_in[0] = q1[0][0] - q1[1][1] - q1[2][2] - q1[3][3];
            s1_in[1] = q1[0][1] + q1[1][0] + q1[2][3] - q1[3][2];
            s1_in[2] = q1[0][2] - q1[1][3] + q1[2][0] + q1[3][1];
            s1_in[3] = q1[0][3] + q1[1][2] - q1[2][1] + q1[3][0];
         end
         qau_pkg::CMD_DOT: begin
            s1_in[0] = q1[0][0] + q1[1][1] + q1[2][2] + q1[3][3];
         end
         qau_pkg::CMD_SCALE: begin
            for (int k = 0; k < 4; k++) s1_in[k] = q1[k][0];
         end
         qau_pkg::CMD_SUM, qau_pkg::CMD_SUB, qau_pkg::CMD_CONJ: begin
            for (int k = 0; k < 4; k++) s1_in[k] = SW'(lin_ff[k]);
         end
         default: begin
            for (int k = 0; k < 4; k++) s1_in[k] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         s1_ff  <= s1_in;
         cs1_ff <= cm1_ff;
         as1_ff <= am1_ff;
      end
   end

   // ---- stage C1: first clamp, conj(a) formed exactly ----
   logic signed [DW-1:0]   t1 [4];
   logic                   sat1;
   logic [qau_pkg::CW-1:0] cc1_ff;
   logic signed [LW-1:0]   cj_ff [4];

   qau_clamp_stage #(.IW(SW)) u_clamp1 (
      .clock (clock),
      .load  (en_c1),
      .val_i (s1_ff),
      .sat_i (1'b0),
      .res_o (t1),
      .sat_o (sat1)
   );

   always_ff @(posedge clock) begin
      if (en_c1) begin
         cc1_ff   <= cs1_ff;
         cj_ff[0] <= LW'(as1_ff[0]);
         cj_ff[1] <= -LW'(as1_ff[1]);
         cj_ff[2] <= -LW'(as1_ff[2]);
         cj_ff[3] <= -LW'(as1_ff[3]);
      end
   end

   // ---- stage M2: second product bank, t times conj(a) ----
   logic signed [P2W-1:0]  p2 [4][4];
   logic [qau_pkg::CW-1:0] cm2_ff;
   logic signed [DW-1:0]   tm2_ff [4];
   logic                   satm2_ff;

   qau_mul_bank #(.AW(DW), .BW(LW)) u_bank2 (
      .clock (clock),
      .load  (en_m2),
      .a_i   (t1),
      .b_i   (cj_ff),
      .p_o   (p2)
   );

   always_ff @(posedge clock) begin
      if (en_m2) begin
         cm2_ff   <= cc1_ff;
         tm2_ff   <= t1;
         satm2_ff <= sat1;
      end
   end

   // ---- stage S2: vector part of the rotation, other ops pass t through ----
   logic signed [P2W-1:0] sh2;
   logic signed [SW-1:0]  q2 [4][4];
   logic signed [SW-1:0]  s2_in [4];
   logic signed [SW-1:0]  s2_ff [4];
   logic                  sats2_ff;

   always_comb begin
      sh2 = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            sh2      = p2[i][j] >>> FRAC_BITS;
            q2[i][j] = sh2[SW-1:0];
         end
      end
   end

   always_comb begin
      if (cm2_ff == qau_pkg::CMD_ROTATE) begin
         s2_in[0] = '0;
         s2_in[1] = q2[0][1] + q2[1][0] + q2[2][3] - q2[3][2];
         s2_in[2] = q2[0][2] - q2[1][3] + q2[2][0] + q2[3][1];
         s2_in[3] = q2[0][3] + q2[1][2] - q2[2][1] + q2[3][0];
      end else begin
         for (int k = 0; k < 4; k++) s2_in[k] = SW'(tm2_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en_s2) begin
         s2_ff    <= s2_in;
         sats2_ff <= satm2_ff;
      end
   end

   // ---- output register: final clamp ----
   logic signed [DW-1:0] r_o [4];
   logic                 sat_o;

   qau_clamp_stage #(.IW(SW)) u_clamp2 (
      .clock (clock),
      .load  (en_o),
      .val_i (s2_ff),
      .sat_i (sats2_ff),
      .res_o (r_o),
      .sat_o (sat_o)
   );

   assign rsp_chan.valid             = vo_ff;
   assign rsp_chan.payload.r_w       = r_o[0];
   assign rsp_chan.payload.r_x       = r_o[1];
   assign rsp_chan.payload.r_y       = r_o[2];
   assign rsp_chan.payload.r_z       = r_o[3];
   assign rsp_chan.payload.saturated = sat_o;

endmodule

// ===== rtl/qau_mul_bank.sv =====
// Registered bank of sixteen signed multipliers, every a_i times every b_j.
// No package dependency.
module qau_mul_bank #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic signed [AW-1:0]    a_i [4],
   input  logic signed [BW-1:0]    b_i [4],
   output logic signed [AW+BW-1:0] p_o [4][4]
);

   localparam int PW = AW + BW;

   logic signed [PW-1:0] p_ff [4][4];

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               p_ff[i][j] <= PW'(a_i[i]) * PW'(b_i[j]);
            end
         end
      end
   end

   assign p_o = p_ff;

endmodule

// ===== rtl/qau_clamp_stage.sv =====
// Registered saturation of four wide lanes to the signed 32-bit range,
// with a sticky flag. Depends on qau_pkg for the limits.
module qau_clamp_stage #(
   parameter int IW = 50
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic signed [IW-1:0]           val_i [4],
   input  logic                           sat_i,
   output logic signed [qau_pkg::DW-1:0]  res_o [4],
   output logic                           sat_o
);

   logic signed [qau_pkg::DW-1:0] res_ff [4];
   logic signed [qau_pkg::DW-1:0] res_in [4];
   logic                          sat_ff;
   logic                          sat_in;
   logic [IW-qau_pkg::DW:0]       hi;

   // in range when every bit above bit 30 equals the sign
   always_comb begin
      sat_in = sat_i;
      hi     = '0;
      for (int k = 0; k < 4; k++) begin
         hi = val_i[k][IW-1:qau_pkg::DW-1];
         if ((&hi) || !(|hi)) begin
            res_in[k] = val_i[k][qau_pkg::DW-1:0];
         end else begin
            sat_in    = 1'b1;
            res_in[k] = val_i[k][IW-1] ? qau_pkg::COMP_MIN : qau_pkg::COMP_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign res_o = res_ff;
   assign sat_o = sat_ff;

endmodule
